### sv/scsp_pkg.sv
// Package: shared types and codes for the sampled call stack profiler.
package scsp_pkg;
    localparam logic [1:0] FUNC_ENTER  = 2'd0;
    localparam logic [1:0] FUNC_EXIT   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] KIND_TRACE     = 2'd0;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd1;
    localparam logic [1:0] KIND_UNDERFLOW = 2'd2;
    localparam logic [1:0] REG_STEP   = 2'd0;
    localparam logic [1:0] REG_MARGIN = 2'd1;
    localparam logic [1:0] REG_IDLE   = 2'd2;
    typedef logic [47:0] time_t;
endpackage

### sv/scsp_stack_ram.sv
// Stack entry memory: one write port, one registered read port.
module scsp_stack_ram #(
    parameter int AW = 10,
    parameter int DW = 210
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/sampled_call_stack_profiler_unit.sv
// Top level: shadow call stack profiler with a memory-held entry stack.
//
// Requests arrive on the s_ channel: tdata holds func, now_time and name_id.
// Results leave on the m_ channel as trace records or status codes.
// An enter writes the new entry in the accepting cycle.
// An exit of an entry that was never sampled only reads the popped entry;
// an exit beyond capacity stays idle, and one on an empty stack returns a status.
// An exit that yields a trace record reads the popped entry, reads the parent,
// writes back the parent and then moves the record into the output register.
// A sample walks the stack one entry per cycle: it reads each entry, stamps it
// if unsampled, then writes the top entry's end times; an idle, overflowing or
// sleeping sample does not walk the stack. The entry memory has one read and
// one write port; this walk sets the sample cost.
// One request is in flight at a time; s_tready is low until its result, if
// any, has moved into the output register.  The output register holds a
// result until the receiver takes it; a stalled receiver holds the block
// once a new result is ready to be placed.
// After reset the stack is empty, times are zero and sampling is asleep;
// the entry memory is not cleared, as every entry is written before read.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module sampled_call_stack_profiler_unit #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func [1:0], now_time [49:2], name_id [65:50], zero pad to 72
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // kind [1:0], rec_name [17:2], rec_start [65:18], rec_duration [113:66],
    // rec_thread_start [161:114], rec_thread_duration [209:162], pad to 216
    output logic [215:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import scsp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = 16 + 1 + 4 * 48;
    localparam logic [16:0] CAP = 17'(STACK_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXIT_RD, ST_EXIT_WR, ST_WALK, ST_WALK_END
    } state_t;

    // Entry word: name, sampled, start, thread start, min end, min thread end
    typedef struct packed {
        logic [15:0] name;
        logic        sampled;
        time_t       start;
        time_t       tstart;
        time_t       min_end;
        time_t       min_tend;
    } entry_t;

    state_t      state_reg;
    logic [15:0] step_reg, idle_limit_reg;
    logic [7:0]  margin_reg;
    logic [15:0] depth_reg, idle_count_reg;
    time_t       last_time_reg, thread_time_reg;
    logic        asleep_reg;
    time_t       now_reg, t_off_reg, thr_off_reg;
    logic [15:0] idx_reg;
    logic        m_valid_reg;
    logic [215:0] m_data_reg, res_data_reg;
    logic        res_pend_reg;
    entry_t      pop_reg, top_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata, stamped;
    logic [DW-1:0] rdata_raw;

    scsp_stack_ram #(.AW(AW), .DW(DW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_raw)
    );
    assign rdata = entry_t'(rdata_raw);

    logic [1:0]  in_func;
    time_t       in_now;
    logic [15:0] in_name;
    assign in_func = s_tdata[1:0];
    assign in_now  = s_tdata[49:2];
    assign in_name = s_tdata[65:50];

    assign s_tready = (state_reg == ST_IDLE) && !res_pend_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    logic  accept;
    logic [15:0] dm1, idx_p1, idx_m1;
    time_t margin48, tt_next, rec_mend;
    assign accept   = s_tvalid && s_tready;
    assign dm1      = depth_reg - 16'd1;
    assign idx_p1   = idx_reg + 16'd1;
    assign idx_m1   = idx_reg - 16'd1;
    assign margin48 = 48'(margin_reg);
    assign tt_next  = thread_time_reg + 48'(step_reg);

    function automatic logic [215:0] status_word(input logic [1:0] k);
        status_word = {214'd0, k};
    endfunction

    // Memory port control.
    always_comb begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        rec_mend = (idx_reg == 16'd0) ? now_reg + margin48 : pop_reg.min_end;
        // Entry under the walk with its start times stamped if still unsampled.
        stamped = rdata;
        if (!rdata.sampled) begin
            stamped.sampled = 1'b1;
            stamped.start   = t_off_reg;
            stamped.tstart  = thr_off_reg;
        end
        if (accept && in_func == FUNC_ENTER && {1'b0, depth_reg} < CAP) begin
            we    = 1'b1;
            waddr = depth_reg[AW-1:0];
            wdata = '0;
            wdata.name = in_name;
        end else if (accept && in_func == FUNC_SAMPLE) begin
            // The walk starts at the bottom of the stack.
            raddr = '0;
        end else if (accept) begin
            raddr = dm1[AW-1:0];
        end
        unique case (state_reg)
            ST_EXIT_RD: begin
                // fetch the parent while the popped entry is captured
                raddr = idx_m1[AW-1:0];
            end
            ST_EXIT_WR: begin
                // write parent's minimum end times
                we    = idx_reg != 16'd0;
                waddr = idx_m1[AW-1:0];
                wdata = rdata;
                wdata.min_end  = pop_reg.min_end + margin48;
                wdata.min_tend = pop_reg.min_tend + margin48;
            end
            ST_WALK: begin
                raddr = idx_p1[AW-1:0];
                if (!rdata.sampled) begin
                    we = 1'b1;
                    wdata = stamped;
                end
            end
            ST_WALK_END: begin
                we = 1'b1;
                waddr = dm1[AW-1:0];
                wdata = top_reg;
                wdata.min_tend = thread_time_reg + margin48;
                wdata.min_end  = now_reg + margin48;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= 16'd100; margin_reg <= 8'd1; idle_limit_reg <= 16'd1000;
            depth_reg <= '0; idle_count_reg <= '0;
            last_time_reg <= '0; thread_time_reg <= '0; asleep_reg <= 1'b1;
            m_valid_reg <= 1'b0; res_pend_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_STEP:   step_reg <= cfg_data;
                    REG_MARGIN: margin_reg <= cfg_data[7:0];
                    REG_IDLE:   idle_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (res_pend_reg && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1; m_data_reg <= res_data_reg;
                res_pend_reg <= 1'b0;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (accept) begin
                    now_reg <= in_now;
                    if (in_func == FUNC_ENTER) begin
                        asleep_reg <= 1'b0;
                        if (asleep_reg || depth_reg == 16'd0) last_time_reg <= in_now;
                        if (depth_reg != 16'hFFFF) depth_reg <= depth_reg + 16'd1;
                    end else if (in_func == FUNC_EXIT) begin
                        asleep_reg <= 1'b0;
                        if (asleep_reg) last_time_reg <= in_now;
                        if (depth_reg == 16'd0) begin
                            res_data_reg <= status_word(KIND_UNDERFLOW);
                            res_pend_reg <= 1'b1;
                        end else begin
                            depth_reg <= dm1;
                            idx_reg   <= dm1;
                            if ({1'b0, dm1} < CAP) state_reg <= ST_EXIT_RD;
                        end
                    end else if (in_func == FUNC_SAMPLE && !asleep_reg) begin
                        t_off_reg <= last_time_reg;
                        thr_off_reg <= thread_time_reg;
                        last_time_reg <= in_now;
                        thread_time_reg <= tt_next;
                        if ({1'b0, depth_reg} >= CAP) begin
                            res_data_reg <= status_word(KIND_OVERFLOW);
                            res_pend_reg <= 1'b1;
                        end else if (depth_reg == 16'd0) begin
                            if (16'(idle_count_reg + 16'd1) >= idle_limit_reg) begin
                                asleep_reg <= 1'b1; idle_count_reg <= '0;
                            end else begin
                                idle_count_reg <= idle_count_reg + 16'd1;
                            end
                        end else begin
                            idx_reg <= '0;
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_EXIT_RD: begin
                    // The popped entry is on the read port; an unsampled one
                    // leaves no record and the parent is left alone.
                    pop_reg <= rdata;
                    state_reg <= rdata.sampled ? ST_EXIT_WR : ST_IDLE;
                end
                ST_EXIT_WR: begin
                    state_reg <= ST_IDLE;
                    res_data_reg <= {6'd0, pop_reg.min_tend - pop_reg.tstart,
                        pop_reg.tstart, rec_mend - pop_reg.start, pop_reg.start,
                        pop_reg.name, KIND_TRACE};
                    res_pend_reg <= 1'b1;
                    if (idx_reg == 16'd0) last_time_reg <= now_reg;
                    else begin
                        last_time_reg <= last_time_reg + margin48;
                        thread_time_reg <= thread_time_reg + margin48;
                    end
                end
                ST_WALK: begin
                    t_off_reg <= t_off_reg + margin48;
                    thr_off_reg <= thr_off_reg + margin48;
                    if (idx_reg == dm1) begin
                        top_reg <= stamped;
                        state_reg <= ST_WALK_END;
                    end else begin
                        idx_reg <= idx_p1;
                    end
                end
                ST_WALK_END: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### dv/sampled_call_stack_profiler_unit_test.sv
// Self-checking testbench for the sampled call stack profiler: directed and random request streams.
module sampled_call_stack_profiler_unit_test;
    import scsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    // Longest gap a request with no result may still be working: a full stack walk.
    localparam int SETTLE_CYCLES = DEPTH + 64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] name;
        time_t       start;
        time_t       duration;
        time_t       thread_start;
        time_t       thread_duration;
    } record_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = REG_STEP;
    logic [15:0]  cfg_data = '0;

    sampled_call_stack_profiler_unit dut (.*);

    // Shadow copy of the profiler state, kept in step with every accepted request.
    logic [15:0] sh_name [DEPTH];
    logic        sh_sampled [DEPTH];
    time_t       sh_start [DEPTH];
    time_t       sh_thread_start [DEPTH];
    time_t       sh_min_end [DEPTH];
    time_t       sh_min_thread_end [DEPTH];
    int          sh_depth;
    time_t       sh_last_time;
    time_t       sh_thread_time;
    logic [15:0] sh_idle_count;
    logic        sh_asleep;
    logic [15:0] step_cfg;
    logic [7:0]  margin_cfg;
    logic [15:0] idle_limit_cfg;

    record_t pending_records[$];
    int      failures = 0;
    bit      calm = 1'b0;     // when set, neither side inserts idle cycles
    time_t   wall_clock = '0; // running wall time used for well-formed streams

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls in roughly one cycle of five unless a calm stretch is running.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    // Works out what one accepted request should produce and advances the shadow state.
    task automatic profile_step(input logic [1:0] func, input time_t now,
                                input logic [15:0] name_id);
        record_t rec;
        time_t   t_off;
        time_t   thr_off;
        int      d;
        rec = '0;
        if (func == FUNC_ENTER) begin
            if (sh_asleep) begin
                sh_last_time = now;
                sh_asleep = 1'b0;
            end
            if (sh_depth == 0) sh_last_time = now;
            if (sh_depth < DEPTH) begin
                sh_name[sh_depth] = name_id;
                sh_sampled[sh_depth] = 1'b0;
            end
            if (sh_depth < 16'hffff) sh_depth++;
        end else if (func == FUNC_EXIT) begin
            if (sh_asleep) begin
                sh_last_time = now;
                sh_asleep = 1'b0;
            end
            if (sh_depth == 0) begin
                rec.kind = KIND_UNDERFLOW;
                pending_records.push_back(rec);
            end else begin
                sh_depth--;
                d = sh_depth;
                if (d < DEPTH && sh_sampled[d]) begin
                    if (d == 0) begin
                        sh_last_time = now;
                        sh_min_end[0] = now + margin_cfg;
                    end
                    rec.kind = KIND_TRACE;
                    rec.name = sh_name[d];
                    rec.start = sh_start[d];
                    rec.duration = sh_min_end[d] - sh_start[d];
                    rec.thread_start = sh_thread_start[d];
                    rec.thread_duration = sh_min_thread_end[d] - sh_thread_start[d];
                    pending_records.push_back(rec);
                    if (d != 0) begin
                        sh_min_end[d-1] = sh_min_end[d] + margin_cfg;
                        sh_min_thread_end[d-1] = sh_min_thread_end[d] + margin_cfg;
                        sh_last_time = sh_last_time + margin_cfg;
                        sh_thread_time = sh_thread_time + margin_cfg;
                    end
                end
            end
        end else if (func == FUNC_SAMPLE && !sh_asleep) begin
            t_off = sh_last_time;
            thr_off = sh_thread_time;
            sh_last_time = now;
            sh_thread_time = sh_thread_time + step_cfg;
            if (sh_depth >= DEPTH) begin
                rec.kind = KIND_OVERFLOW;
                pending_records.push_back(rec);
            end else begin
                for (int i = 0; i < sh_depth; i++) begin
                    if (!sh_sampled[i]) begin
                        sh_start[i] = t_off;
                        sh_thread_start[i] = thr_off;
                        sh_sampled[i] = 1'b1;
                    end
                    t_off = t_off + margin_cfg;
                    thr_off = thr_off + margin_cfg;
                end
                if (sh_depth != 0) begin
                    sh_min_thread_end[sh_depth-1] = sh_thread_time + margin_cfg;
                    sh_min_end[sh_depth-1] = now + margin_cfg;
                end else begin
                    sh_idle_count = sh_idle_count + 16'd1;
                    if (sh_idle_count >= idle_limit_cfg) begin
                        sh_asleep = 1'b1;
                        sh_idle_count = '0;
                    end
                end
            end
        end
    endtask

    // Sends one request, with random idle cycles in front unless a calm stretch is running.
    // The valid line is only lowered inside a gap, so back-to-back requests keep it high.
    task automatic send_request(input logic [1:0] func, input time_t now,
                                input logic [15:0] name_id);
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {8'd0, name_id, now, func};
        do @(posedge aclk); while (!s_tready);
        profile_step(func, now, name_id);
    endtask

    // Waits until every expected result has arrived and any walk still running has ended.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        case (index)
            REG_STEP:   step_cfg = value;
            REG_MARGIN: margin_cfg = value[7:0];
            REG_IDLE:   idle_limit_cfg = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] step, input logic [7:0] margin,
                             input logic [15:0] limit);
        drain();
        write_register(REG_STEP, step);
        write_register(REG_MARGIN, {8'd0, margin});
        write_register(REG_IDLE, limit);
        cfg_we <= 1'b0;
    endtask

    // Each result is compared with the oldest outstanding expectation.
    always @(posedge aclk) begin
        record_t got;
        record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[17:2], m_tdata[65:18], m_tdata[113:66],
                   m_tdata[161:114], m_tdata[209:162]};
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $realtime, got);
                failures++;
            end else begin
                want = pending_records.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected %h, actual %h",
                             $realtime, want, got);
                    failures++;
                end
            end
        end
    end

    // Extremes of the fields and each special case, under the reset settings.
    task automatic test_directed;
        time_t top;
        top = 48'hffff_ffff_fff0;
        send_request(FUNC_EXIT, 48'd5, 16'h0000);      // exit on an empty stack
        send_request(2'd3, '1, '1);                      // unknown function code
        send_request(FUNC_SAMPLE, 48'd9, 16'h1234);     // sample while asleep
        send_request(FUNC_ENTER, top, 16'hffff);
        send_request(FUNC_ENTER, top + 2, 16'h0000);
        send_request(FUNC_SAMPLE, top + 8, 16'h5555);
        send_request(FUNC_SAMPLE, top + 30, 16'haaaa);  // wall time wraps here
        send_request(FUNC_EXIT, top + 40, 16'h0000);
        send_request(FUNC_EXIT, top + 50, 16'h0000);
        send_request(FUNC_EXIT, top + 60, 16'h0000);
        send_request(FUNC_ENTER, '1, 16'h8001);
        send_request(FUNC_ENTER, 48'd3, 16'h7ffe);
        send_request(FUNC_EXIT, 48'd4, 16'h0000);       // unsampled entry leaves quietly
        send_request(FUNC_SAMPLE, 48'd10, 16'h0000);
        send_request(FUNC_ENTER, 48'd12, 16'h00ff);
        send_request(FUNC_SAMPLE, 48'h8000_0000_0000, 16'h0000);
        send_request(FUNC_EXIT, 48'h8000_0000_0100, 16'h0000);
        send_request(FUNC_EXIT, 48'h8000_0000_0200, 16'h0000);
        send_request(FUNC_SAMPLE, 48'h8000_0000_0300, 16'h0000);
        wall_clock = 48'h8000_0000_1000;
    endtask

    // Samples on an empty stack until sampling sleeps, at idle limits of 0, 1 and 3.
    task automatic test_idle_sleep;
        configure(16'd1, 8'd0, 16'd0);
        send_request(FUNC_ENTER, wall_clock, 16'h0001);
        send_request(FUNC_EXIT, wall_clock + 1, 16'h0000);
        repeat (3) send_request(FUNC_SAMPLE, wall_clock + 2, 16'h0000);
        configure(16'd7, 8'd3, 16'd1);
        send_request(FUNC_EXIT, wall_clock + 3, 16'h0000);
        repeat (3) send_request(FUNC_SAMPLE, wall_clock + 4, 16'h0000);
        configure(16'hffff, 8'hff, 16'd3);
        send_request(FUNC_ENTER, wall_clock + 5, 16'h0002);
        send_request(FUNC_EXIT, wall_clock + 6, 16'h0000);
        repeat (5) send_request(FUNC_SAMPLE, wall_clock + 7, 16'h0000);
        send_request(FUNC_ENTER, wall_clock + 8, 16'h0003);
        send_request(FUNC_SAMPLE, wall_clock + 9, 16'h0000);
        send_request(FUNC_EXIT, wall_clock + 10, 16'h0000);
        wall_clock = wall_clock + 11;
    endtask

    // Fills the stack past its capacity, samples there, then unwinds it completely.
    task automatic test_deep_stack;
        configure(16'd100, 8'd1, 16'hffff);
        calm = 1'b1;
        for (int i = 0; i < DEPTH - 1; i++)
            send_request(FUNC_ENTER, wall_clock + i, 16'($urandom));
        send_request(FUNC_SAMPLE, wall_clock + 2000, 16'h0000);
        calm = 1'b0;
        repeat (3) send_request(FUNC_ENTER, wall_clock + 2100, 16'($urandom));
        send_request(FUNC_SAMPLE, wall_clock + 2200, 16'h0000);  // stack too deep
        while (sh_depth > 0) send_request(FUNC_EXIT, wall_clock + 3000, 16'h0000);
        wall_clock = wall_clock + 4000;
    endtask

    // Random well-formed call trees with random content, plus some noise.
    task automatic test_random(input int count);
        int          roll;
        logic [1:0]  func;
        logic [15:0] name_id;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3) && (n < count / 3 + 150);
            roll = $urandom_range(99);
            if (roll < 4) begin
                func = 2'($urandom);
            end else if (sh_depth == 0) begin
                func = (roll < 70) ? FUNC_ENTER : (roll < 90 ? FUNC_SAMPLE : FUNC_EXIT);
            end else if (sh_depth > 24) begin
                func = (roll < 75) ? FUNC_EXIT : FUNC_SAMPLE;
            end else begin
                func = (roll < 45) ? FUNC_ENTER : (roll < 75 ? FUNC_EXIT : FUNC_SAMPLE);
            end
            if ($urandom_range(49) == 0)
                wall_clock = {16'($urandom), 32'($urandom)};
            else
                wall_clock = wall_clock + $urandom_range(0, 1000);
            name_id = 16'($urandom);
            send_request(func, wall_clock, name_id);
        end
        calm = 1'b0;
    endtask

    initial begin
        sh_depth = 0;
        sh_last_time = '0;
        sh_thread_time = '0;
        sh_idle_count = '0;
        sh_asleep = 1'b1;
        step_cfg = 16'd100;
        margin_cfg = 8'd1;
        idle_limit_cfg = 16'd1000;
        for (int i = 0; i < DEPTH; i++) begin
            sh_name[i] = '0;
            sh_sampled[i] = 1'b0;
            sh_start[i] = '0;
            sh_thread_start[i] = '0;
            sh_min_end[i] = '0;
            sh_min_thread_end[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_idle_sleep();
        test_deep_stack();
        configure(16'd1, 8'd0, 16'd2);
        test_random(60);
        configure(16'hffff, 8'hff, 16'hffff);
        test_random(60);
        configure(16'd100, 8'd1, 16'd1000);
        test_random(60);
        configure(16'($urandom_range(1, 65535)), 8'($urandom), 16'($urandom_range(1, 40)));
        test_random(60);
        drain();

        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Backstop for a hung handshake.
    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
